// File: rtl/wrsi_pkg.sv
// Shared types and constants for the streaming Wilder RSI block.
// Used by every module of the block except wrsi_fifo; depends on nothing else.
package wrsi_pkg;

  localparam int PRICE_W  = 32;
  localparam int PERIOD_W = 10;
  localparam int SEEN_W   = 11;
  localparam int RSI_W    = 14;
  localparam int SUM_W    = 42;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd14;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 10'd1;
  localparam logic [RSI_W-1:0]    RSI_FULL     = 14'd10000;

  typedef enum logic [1:0] {
    OP_FIRST   = 2'd0,
    OP_ACCUM   = 2'd1,
    OP_AVERAGE = 2'd2,
    OP_SMOOTH  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [PRICE_W-1:0] gain;
    logic [PRICE_W-1:0] loss;
  } entry_t;

  typedef struct packed {
    logic [RSI_W-1:0] value;
    logic             valid;
  } res_t;

endpackage

// File: rtl/wilder_rsi_stream.sv
// Top level of the streaming Wilder RSI block: period register, front end,
// item queue, back end and result queue. Depends on wrsi_pkg and all wrsi_ modules.
//
// One closing price goes in per transfer on the in_ channel (in_push, in_full),
// and exactly one result per price comes out on the out_ channel (out_empty,
// out_pop) in arrival order. The front end classifies each price in the cycle
// it is taken and places it in a two-entry queue; the back end works on one
// item at a time. A warm-up item goes straight to the back end's output
// state; the item that closes warm-up and every later item pass through the
// bit-serial division by the period (one quotient bit per cycle) and the
// 14-step ratio multiply and division, later items also through the 10-step
// multiply by period-1 first; the ratio steps are skipped when the average
// loss is zero. The next item starts as soon as the back end is free.
// Reset clears all history and sets the period to 14. A write on cfg_we also
// clears the history, so warm-up starts again. If the receiver stalls, up to
// two results wait in the output queue, the back end holds its finished
// result, and in_full rises once the item queue is full; nothing is dropped.
module wilder_rsi_stream #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wrsi_pkg::PERIOD_W-1:0] cfg_smoothing_period,
  input  logic                          in_push,
  input  logic [wrsi_pkg::PRICE_W-1:0]  in_close_price,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [wrsi_pkg::RSI_W-1:0]    out_rsi_value,
  output logic                          out_rsi_valid
);

  logic [wrsi_pkg::PERIOD_W-1:0] period_r;
  logic [wrsi_pkg::PERIOD_W-1:0] period_eff;
  wrsi_pkg::entry_t              q_wdata, q_rdata;
  logic                          q_push, q_full, q_pop, q_empty;
  wrsi_pkg::res_t                r_wdata, r_rdata;
  logic                          r_push, r_full;

  assign period_eff = (period_r == '0) ? wrsi_pkg::PERIOD_MIN : period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= wrsi_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_smoothing_period;
    end
  end

  wrsi_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .clear          (cfg_we),
    .period         (period_eff),
    .in_push        (in_push),
    .in_close_price (in_close_price),
    .in_full        (in_full),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  wrsi_fifo #(
    .WIDTH ($bits(wrsi_pkg::entry_t)),
    .DEPTH (2)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  wrsi_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (cfg_we),
    .period  (period_eff),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_rdata),
    .r_full  (r_full),
    .r_push  (r_push),
    .r_data  (r_wdata)
  );

  wrsi_fifo #(
    .WIDTH ($bits(wrsi_pkg::res_t)),
    .DEPTH (2)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .wdata (r_wdata),
    .full  (r_full),
    .pop   (out_pop),
    .rdata (r_rdata),
    .empty (out_empty)
  );

  assign out_rsi_value = r_rdata.value;
  assign out_rsi_valid = r_rdata.valid;

endmodule

// File: rtl/wrsi_fifo.sv
// Small register queue used between the front, the back and the result port.
// Generic payload width; no package dependencies.
module wrsi_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/wrsi_front.sv
// Front end: takes closing prices, forms the gain and loss of each change
// and tags the item with its warm-up phase. Depends on wrsi_pkg.
module wrsi_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              clear,
  input  logic [wrsi_pkg::PERIOD_W-1:0]     period,
  input  logic                              in_push,
  input  logic [wrsi_pkg::PRICE_W-1:0]      in_close_price,
  output logic                              in_full,
  input  logic                              q_full,
  output logic                              q_push,
  output wrsi_pkg::entry_t                  q_data
);

  logic [wrsi_pkg::PRICE_W-1:0] prev_r, prev_nxt;
  logic [wrsi_pkg::SEEN_W-1:0]  seen_r, seen_nxt;
  logic [wrsi_pkg::SEEN_W-1:0]  period_ext;
  logic                         accept;

  assign in_full    = q_full;
  assign accept     = in_push & ~q_full;
  assign q_push     = accept;
  assign period_ext = {1'b0, period};

  always_comb begin
    q_data.gain = '0;
    q_data.loss = '0;
    if (in_close_price > prev_r) begin
      q_data.gain = in_close_price - prev_r;
    end else begin
      q_data.loss = prev_r - in_close_price;
    end

    seen_nxt = seen_r;
    priority if (seen_r == '0) begin
      q_data.op = wrsi_pkg::OP_FIRST;
      seen_nxt  = wrsi_pkg::SEEN_W'(1);
    end else if (seen_r < period_ext) begin
      q_data.op = wrsi_pkg::OP_ACCUM;
      seen_nxt  = seen_r + 1'b1;
    end else if (seen_r == period_ext) begin
      q_data.op = wrsi_pkg::OP_AVERAGE;
      seen_nxt  = period_ext + 1'b1;
    end else begin
      q_data.op = wrsi_pkg::OP_SMOOTH;
    end

    prev_nxt = prev_r;
    if (!accept) begin
      seen_nxt = seen_r;
    end else begin
      prev_nxt = in_close_price;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      prev_r <= '0;
      seen_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// File: rtl/wrsi_avg_unit.sv
// Serial average update: a shift-add multiply by period-1 (smoothing only),
// then a restoring division by the period, one bit per cycle. Depends on wrsi_pkg.
module wrsi_avg_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                                      clk,
  input  logic                                                      rst_n,
  input  logic                                                      start,
  input  logic                                                      smooth,
  input  logic [((wrsi_pkg::PRICE_W + FRACTION_BITS > wrsi_pkg::SUM_W) ?
                 (wrsi_pkg::PRICE_W + FRACTION_BITS) : wrsi_pkg::SUM_W)-1:0] src,
  input  logic [wrsi_pkg::PRICE_W-1:0]                              x,
  input  logic [wrsi_pkg::PERIOD_W-1:0]                             period,
  output logic                                                      done,
  output logic [wrsi_pkg::PRICE_W+FRACTION_BITS-1:0]                avg
);

  localparam int AVG_W = wrsi_pkg::PRICE_W + FRACTION_BITS;
  localparam int NUM_W = AVG_W + wrsi_pkg::PERIOD_W + 1;
  localparam int CNT_W = $clog2(AVG_W + 1);
  localparam int PW    = wrsi_pkg::PERIOD_W;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_ADD  = 4'b0100,
    L_DIV  = 4'b1000
  } lane_state_t;

  lane_state_t      state_r, state_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [PW-1:0]    mul_r, mul_nxt;
  logic [PW-1:0]    rem_r, rem_nxt;
  logic [AVG_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [NUM_W-1:0] num_step, num_add;
  logic [PW:0]      trial;
  logic             ge;

  assign done = done_r;
  assign avg  = quo_r;

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    mul_nxt   = mul_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;

    num_step = (num_r << 1) + (mul_r[PW-1] ? NUM_W'(src[AVG_W-1:0]) : '0);
    num_add  = num_r + (NUM_W'(x) << FRACTION_BITS);
    trial    = {rem_r, quo_r[AVG_W-1]};
    ge       = (trial >= {1'b0, period});

    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          cnt_nxt = CNT_W'(PW - 1);
          mul_nxt = period - 1'b1;
          if (smooth) begin
            num_nxt   = '0;
            state_nxt = L_MUL;
          end else begin
            num_nxt   = NUM_W'(src) << FRACTION_BITS;
            state_nxt = L_ADD;
          end
        end
      end
      L_MUL: begin
        num_nxt = num_step;
        mul_nxt = mul_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = L_ADD;
        end
      end
      L_ADD: begin
        rem_nxt   = num_add[AVG_W +: PW];
        quo_nxt   = num_add[AVG_W-1:0];
        cnt_nxt   = CNT_W'(AVG_W - 1);
        state_nxt = L_DIV;
      end
      L_DIV: begin
        rem_nxt = ge ? PW'(trial - {1'b0, period}) : trial[PW-1:0];
        quo_nxt = {quo_r[AVG_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    mul_r <= mul_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// File: rtl/wrsi_back.sv
// Back end: keeps the gain and loss averages, updates them through two
// serial average units and forms the RSI ratio. Depends on wrsi_pkg, wrsi_avg_unit.
module wrsi_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic [wrsi_pkg::PERIOD_W-1:0] period,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  wrsi_pkg::entry_t              q_data,
  input  logic                          r_full,
  output logic                          r_push,
  output wrsi_pkg::res_t                r_data
);

  localparam int AVG_W  = wrsi_pkg::PRICE_W + FRACTION_BITS;
  localparam int ST_W   = (AVG_W > wrsi_pkg::SUM_W) ? AVG_W : wrsi_pkg::SUM_W;
  localparam int RSI_W  = wrsi_pkg::RSI_W;
  localparam int ACC_W  = RSI_W + AVG_W;
  localparam int RCNT_W = $clog2(RSI_W);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LANE = 5'b00010,
    S_MULK = 5'b00100,
    S_RDIV = 5'b01000,
    S_OUT  = 5'b10000
  } back_state_t;

  back_state_t       state_r, state_nxt;
  wrsi_pkg::entry_t  ent_r, ent_nxt;
  logic [ST_W-1:0]   gain_r, gain_nxt;
  logic [ST_W-1:0]   loss_r, loss_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_step;
  logic [RSI_W-1:0]  k_r, k_nxt;
  logic [RCNT_W-1:0] cnt_r, cnt_nxt;
  logic [AVG_W:0]    sum_r, sum_nxt;
  logic [AVG_W:0]    rem_r, rem_nxt;
  logic [RSI_W-1:0]  quo_r, quo_nxt;
  wrsi_pkg::res_t    res_r, res_nxt;
  logic [AVG_W+1:0]  trial;
  logic              ge;
  logic              lane_start, lane_smooth;
  logic              g_done, l_done;
  logic [AVG_W-1:0]  g_avg, l_avg;

  wrsi_avg_unit #(.FRACTION_BITS(FRACTION_BITS)) u_gain (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .smooth (lane_smooth),
    .src    (gain_r),
    .x      (ent_r.gain),
    .period (period),
    .done   (g_done),
    .avg    (g_avg)
  );

  wrsi_avg_unit #(.FRACTION_BITS(FRACTION_BITS)) u_loss (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .smooth (lane_smooth),
    .src    (loss_r),
    .x      (ent_r.loss),
    .period (period),
    .done   (l_done),
    .avg    (l_avg)
  );

  assign r_data      = res_r;
  assign lane_smooth = (q_data.op == wrsi_pkg::OP_SMOOTH);

  always_comb begin
    state_nxt  = state_r;
    ent_nxt    = ent_r;
    gain_nxt   = gain_r;
    loss_nxt   = loss_r;
    acc_nxt    = acc_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    res_nxt    = res_r;
    q_pop      = 1'b0;
    r_push     = 1'b0;
    lane_start = 1'b0;

    acc_step = (acc_r << 1) + (k_r[RSI_W-1] ? ACC_W'(gain_r[AVG_W-1:0]) : '0);
    trial    = {rem_r, quo_r[RSI_W-1]};
    ge       = (trial >= {1'b0, sum_r});

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_data;
          unique case (q_data.op)
            wrsi_pkg::OP_FIRST: begin
              res_nxt   = '{value: '0, valid: 1'b0};
              state_nxt = S_OUT;
            end
            wrsi_pkg::OP_ACCUM: begin
              gain_nxt  = gain_r + ST_W'(q_data.gain);
              loss_nxt  = loss_r + ST_W'(q_data.loss);
              res_nxt   = '{value: '0, valid: 1'b0};
              state_nxt = S_OUT;
            end
            wrsi_pkg::OP_AVERAGE, wrsi_pkg::OP_SMOOTH: begin
              lane_start = 1'b1;
              state_nxt  = S_LANE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LANE: begin
        if (g_done && l_done) begin
          gain_nxt = ST_W'(g_avg);
          loss_nxt = ST_W'(l_avg);
          if (l_avg == '0) begin
            res_nxt   = '{value: wrsi_pkg::RSI_FULL, valid: 1'b1};
            state_nxt = S_OUT;
          end else begin
            sum_nxt   = {1'b0, g_avg} + {1'b0, l_avg};
            acc_nxt   = '0;
            k_nxt     = wrsi_pkg::RSI_FULL;
            cnt_nxt   = RCNT_W'(RSI_W - 1);
            state_nxt = S_MULK;
          end
        end
      end
      S_MULK: begin
        acc_nxt = acc_step;
        k_nxt   = k_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          rem_nxt   = {1'b0, acc_step[ACC_W-1:RSI_W]};
          quo_nxt   = acc_step[RSI_W-1:0];
          cnt_nxt   = RCNT_W'(RSI_W - 1);
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        rem_nxt = ge ? (AVG_W + 1)'(trial - {1'b0, sum_r}) : trial[AVG_W:0];
        quo_nxt = {quo_r[RSI_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          res_nxt   = '{value: quo_nxt, valid: 1'b1};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!r_full) begin
          r_push    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      state_r <= S_IDLE;
      gain_r  <= '0;
      loss_r  <= '0;
    end else begin
      state_r <= state_nxt;
      gain_r  <= gain_nxt;
      loss_r  <= loss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    acc_r <= acc_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    sum_r <= sum_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    res_r <= res_nxt;
  end

endmodule
